/* design/json_string_unescape_unit_defines.svh */
// assertion macros for the json string unescape unit
// no dependencies
`ifndef JSON_STRING_UNESCAPE_UNIT_DEFINES_SVH
`define JSON_STRING_UNESCAPE_UNIT_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define JSU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent implies consequent in the next cycle, checked during reset too
`define JSU_ASSERT_NEXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* design/jsu_pkg.sv */
// types and constants for the json string unescape unit
// no dependencies
package jsu_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CAP_W   = 13;
    localparam int unsigned COUNT_W = 12;
    localparam int unsigned HEX_W   = 16;
    localparam int unsigned STAT_W  = 2;
    localparam int unsigned OUT_W   = 24;

    localparam logic [STAT_W-1:0] ST_BUSY  = 2'd0;
    localparam logic [STAT_W-1:0] ST_DONE  = 2'd1;
    localparam logic [STAT_W-1:0] ST_ERROR = 2'd2;

    localparam logic [CAP_W-1:0]   CAP_RESET = 13'd64;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 12'd4095;

    localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
    localparam logic [BYTE_W-1:0] CH_BSL   = 8'h5c;
    localparam logic [HEX_W-1:0]  PRINT_LO = 16'h0020;
    localparam logic [HEX_W-1:0]  PRINT_HI = 16'h007e;

    typedef enum logic [6:0] {
        PH_IDLE = 7'b0000001,
        PH_BODY = 7'b0000010,
        PH_ESC  = 7'b0000100,
        PH_HEX1 = 7'b0001000,
        PH_HEX2 = 7'b0010000,
        PH_HEX3 = 7'b0100000,
        PH_HEX4 = 7'b1000000
    } t_phase;

    typedef struct packed {
        logic [COUNT_W-1:0] stored_count;
        logic [STAT_W-1:0]  status;
        logic [BYTE_W-1:0]  out_char;
    } t_result;

endpackage

/* design/json_string_unescape_unit.sv */
// json string unescape unit: top level
// depends on jsu_pkg
//
// Unescapes a quoted JSON string fed one byte per transfer (zero byte marks end of
// text). Each input transfer yields exactly one output transfer carrying the decoded
// character (with a valid flag in tuser), a status (0 in progress, 1 closing quote,
// 2 error) and the running stored count. One byte is taken per cycle unless the output
// stalls; each byte goes through the input register and then the result register.
// The capacity register may only be written while no transfer is in flight.
module json_string_unescape_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [12:0] i_cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] out_char, [9:8] status, [21:10] stored_count
    output logic        m_axis_tuser    // [0] char_valid
);

    logic [jsu_pkg::CAP_W-1:0]   r_cap;
    logic                        r_in_vld;
    logic [jsu_pkg::BYTE_W-1:0]  r_in_byte;
    jsu_pkg::t_phase             r_phase, n_phase;
    logic [jsu_pkg::HEX_W-1:0]   r_hex, n_hex;
    logic                        r_hex_stop, n_hex_stop;
    logic [jsu_pkg::COUNT_W-1:0] r_count, n_count;
    logic                        r_out_vld;
    jsu_pkg::t_result            r_out, n_out;
    logic                        r_out_cv, n_out_cv;

    logic                        advance;
    logic                        can_store;
    logic                        want_store;
    logic [jsu_pkg::BYTE_W-1:0]  store_ch;
    logic                        is_hex;
    logic [3:0]                  hex_dig;
    logic [jsu_pkg::HEX_W-1:0]   hex_next;
    logic [jsu_pkg::BYTE_W-1:0]  b;

    assign advance       = !r_out_vld || m_axis_tready;
    assign s_axis_tready = !r_in_vld || advance;
    assign b             = r_in_byte;

    assign can_store = (r_count != jsu_pkg::COUNT_MAX)
        && (({1'b0, r_count} + 13'd1) < r_cap);

    always_comb begin
        is_hex  = 1'b1;
        hex_dig = 4'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            hex_dig = 4'(b - 8'h30);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            hex_dig = 4'(b - 8'h57);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            hex_dig = 4'(b - 8'h37);
        end else begin
            is_hex = 1'b0;
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_hex      = r_hex;
        n_hex_stop = r_hex_stop;
        n_count    = r_count;
        want_store = 1'b0;
        store_ch   = b;
        hex_next   = r_hex;
        n_out          = '0;
        n_out.status   = jsu_pkg::ST_BUSY;
        if (r_phase == jsu_pkg::PH_IDLE) begin
            if (b == jsu_pkg::CH_QUOTE) begin
                n_phase = jsu_pkg::PH_BODY;
                n_count = '0;
            end else begin
                n_out.status = jsu_pkg::ST_ERROR;
            end
        end else if (b == jsu_pkg::CH_NUL) begin
            n_out.status = jsu_pkg::ST_ERROR;
            n_phase      = jsu_pkg::PH_IDLE;
        end else begin
            case (r_phase)
                jsu_pkg::PH_BODY: begin
                    if (b == jsu_pkg::CH_QUOTE) begin
                        n_out.status = jsu_pkg::ST_DONE;
                        n_phase      = jsu_pkg::PH_IDLE;
                    end else if (b == jsu_pkg::CH_BSL) begin
                        n_phase = jsu_pkg::PH_ESC;
                    end else begin
                        want_store = 1'b1;
                    end
                end
                jsu_pkg::PH_ESC: begin
                    n_phase    = jsu_pkg::PH_BODY;
                    want_store = 1'b1;
                    case (b)
                        8'h6e: store_ch = 8'h0a;
                        8'h74: store_ch = 8'h09;
                        8'h72: store_ch = 8'h0d;
                        8'h62: store_ch = 8'h08;
                        8'h66: store_ch = 8'h0c;
                        8'h75: begin
                            n_phase    = jsu_pkg::PH_HEX1;
                            n_hex      = '0;
                            n_hex_stop = 1'b0;
                            want_store = 1'b0;
                        end
                        default: store_ch = b;
                    endcase
                end
                jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2, jsu_pkg::PH_HEX3,
                jsu_pkg::PH_HEX4: begin
                    if (!r_hex_stop && is_hex) begin
                        hex_next = {r_hex[jsu_pkg::HEX_W-5:0], hex_dig};
                    end else begin
                        n_hex_stop = 1'b1;
                    end
                    n_hex = hex_next;
                    case (r_phase)
                        jsu_pkg::PH_HEX1: n_phase = jsu_pkg::PH_HEX2;
                        jsu_pkg::PH_HEX2: n_phase = jsu_pkg::PH_HEX3;
                        jsu_pkg::PH_HEX3: n_phase = jsu_pkg::PH_HEX4;
                        default: begin
                            n_phase    = jsu_pkg::PH_BODY;
                            store_ch   = hex_next[jsu_pkg::BYTE_W-1:0];
                            want_store = (hex_next >= jsu_pkg::PRINT_LO)
                                && (hex_next <= jsu_pkg::PRINT_HI);
                        end
                    endcase
                end
                default: begin
                    n_phase      = jsu_pkg::PH_IDLE;
                    n_out.status = jsu_pkg::ST_ERROR;
                end
            endcase
        end
        n_out_cv = want_store && can_store;
        if (n_out_cv) begin
            n_count        = r_count + 12'd1;
            n_out.out_char = store_ch;
        end
        n_out.stored_count = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap      <= jsu_pkg::CAP_RESET;
            r_in_vld   <= 1'b0;
            r_phase    <= jsu_pkg::PH_IDLE;
            r_hex      <= '0;
            r_hex_stop <= 1'b0;
            r_count    <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_cap <= i_cfg_wr_data;
            end
            if (s_axis_tready) begin
                r_in_vld <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_vld <= r_in_vld;
            end
            if (advance && r_in_vld) begin
                r_phase    <= n_phase;
                r_hex      <= n_hex;
                r_hex_stop <= n_hex_stop;
                r_count    <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
        end
        if (advance && r_in_vld) begin
            r_out    <= n_out;
            r_out_cv <= n_out_cv;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {2'b00, r_out};
    assign m_axis_tuser  = r_out_cv;

endmodule

/* design/jsu_checker.sv */
// port checker for the json string unescape unit, bound to the top level
// depends on json_string_unescape_unit_defines.svh and jsu_pkg
`include "json_string_unescape_unit_defines.svh"

module jsu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    `JSU_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n && m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    `JSU_ASSERT_NEXT(a_reset_clears, i_clk, !i_rst_n, !m_axis_tvalid)
    `JSU_ASSERT_IMPL(a_char_busy, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tdata[9:8] == jsu_pkg::ST_BUSY && m_axis_tdata[21:10] != 12'd0)
    `JSU_ASSERT_IMPL(a_no_char_zero, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[7:0] == 8'd0 && m_axis_tdata[9:8] != 2'd3)

endmodule

bind json_string_unescape_unit jsu_checker u_jsu_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

/* dv/jsu_unescape_sb_pkg.sv */
`timescale 1ns / 100ps
// scoreboard for the json string unescape unit: byte-level decoder model
// and in-order check of the output transfers; depends on jsu_pkg
package jsu_unescape_sb_pkg;
    import jsu_pkg::*;

    localparam logic [BYTE_W-1:0] CH_LF  = 8'h0a;
    localparam logic [BYTE_W-1:0] CH_TAB = 8'h09;
    localparam logic [BYTE_W-1:0] CH_CR  = 8'h0d;
    localparam logic [BYTE_W-1:0] CH_BS  = 8'h08;
    localparam logic [BYTE_W-1:0] CH_FF  = 8'h0c;

    typedef struct packed {
        logic               char_valid;
        logic [COUNT_W-1:0] stored_count;
        logic [STAT_W-1:0]  status;
        logic [BYTE_W-1:0]  out_char;
    } t_decoded;

    class unescape_scoreboard;
        logic [CAP_W-1:0]   capacity;
        t_phase             phase;
        logic [HEX_W-1:0]   hex_value;
        bit                 hex_stopped;
        logic [COUNT_W-1:0] char_count;
        t_decoded           decoded_q[$];
        int unsigned        mismatches;

        function new();
            capacity    = CAP_RESET;
            phase       = PH_IDLE;
            hex_value   = '0;
            hex_stopped = 1'b0;
            char_count  = '0;
            mismatches  = 0;
        endfunction

        function void set_capacity(logic [CAP_W-1:0] value);
            capacity = value;
        endfunction

        function int pending();
            return decoded_q.size();
        endfunction

        // advance the decoder by one accepted byte and queue its output
        function void decode_byte(logic [BYTE_W-1:0] b);
            t_decoded         r;
            logic [BYTE_W-1:0] c;
            bit               want;
            int               nib;
            r    = '0;
            c    = b;
            want = 1'b0;
            nib  = -1;
            if (phase == PH_IDLE) begin
                if (b == CH_QUOTE) begin
                    phase      = PH_BODY;
                    char_count = '0;
                end else begin
                    r.status = ST_ERROR;
                end
            end else if (b == CH_NUL) begin
                r.status = ST_ERROR;
                phase    = PH_IDLE;
            end else if (phase == PH_BODY) begin
                if (b == CH_QUOTE) begin
                    r.status = ST_DONE;
                    phase    = PH_IDLE;
                end else if (b == CH_BSL) begin
                    phase = PH_ESC;
                end else begin
                    want = 1'b1;
                end
            end else if (phase == PH_ESC) begin
                phase = PH_BODY;
                want  = 1'b1;
                case (b)
                    "n": c = CH_LF;
                    "t": c = CH_TAB;
                    "r": c = CH_CR;
                    "b": c = CH_BS;
                    "f": c = CH_FF;
                    "u": begin
                        phase       = PH_HEX1;
                        hex_value   = '0;
                        hex_stopped = 1'b0;
                        want        = 1'b0;
                    end
                    default: ;
                endcase
            end else begin
                if (b >= "0" && b <= "9") nib = int'(b - "0");
                else if (b >= "a" && b <= "f") nib = int'(b - "a") + 10;
                else if (b >= "A" && b <= "F") nib = int'(b - "A") + 10;
                if (!hex_stopped && nib >= 0) hex_value = {hex_value[HEX_W-5:0], nib[3:0]};
                else hex_stopped = 1'b1;
                case (phase)
                    PH_HEX1: phase = PH_HEX2;
                    PH_HEX2: phase = PH_HEX3;
                    PH_HEX3: phase = PH_HEX4;
                    default: begin
                        phase = PH_BODY;
                        want  = (hex_value >= PRINT_LO && hex_value <= PRINT_HI);
                        c     = hex_value[BYTE_W-1:0];
                    end
                endcase
            end
            // full buffer drops the character silently
            if (want && char_count < COUNT_MAX && int'(char_count) + 1 < int'(capacity)) begin
                char_count   = char_count + 1'b1;
                r.char_valid = 1'b1;
                r.out_char   = c;
            end
            r.stored_count = char_count;
            decoded_q.push_back(r);
        endfunction

        function void compare(string field, int unsigned want, int unsigned got);
            if (want != got) begin
                mismatches++;
                $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, field, want, got);
            end
        endfunction

        function void check_output(logic [OUT_W-1:0] tdata, logic tuser);
            t_decoded r;
            if (decoded_q.size() == 0) begin
                mismatches++;
                $display("%0t ns: unexpected output transfer, expected none actual %h/%b",
                         $time, tdata, tuser);
                return;
            end
            r = decoded_q.pop_front();
            compare("out_char", r.out_char, tdata[7:0]);
            compare("status", r.status, tdata[9:8]);
            compare("stored_count", r.stored_count, tdata[21:10]);
            compare("tdata pad", 0, tdata[23:22]);
            compare("char_valid", r.char_valid, tuser);
        endfunction
    endclass

endpackage

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// top-level testbench for json_string_unescape_unit: bursty byte stream in,
// stalling receiver out, capacity changed between phases; depends on jsu_pkg
// and jsu_unescape_sb_pkg
module tb_top;
    import jsu_pkg::*;
    import jsu_unescape_sb_pkg::*;

    typedef enum int {RX_ALWAYS, RX_COIN, RX_MOSTLY, RX_PERIODIC} t_rx_mode;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_cfg_wr_en   = 1'b0;
    logic [CAP_W-1:0]  i_cfg_wr_data = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [BYTE_W-1:0] s_axis_tdata  = '0;  // [7:0] in_byte
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_W-1:0]  m_axis_tdata;        // [7:0] out_char, [9:8] status, [21:10] stored_count
    logic              m_axis_tuser;        // [0] char_valid

    unescape_scoreboard sb;
    logic [BYTE_W-1:0]  byte_q[$];

    t_rx_mode rx_mode   = RX_ALWAYS;
    int       rx_left   = 0;
    int       rx_period = 4;
    int       rx_tick   = 0;

    json_string_unescape_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // receiver stall pattern
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode   = t_rx_mode'($urandom_range(0, 3));
            rx_left   = $urandom_range(16, 200);
            rx_period = $urandom_range(2, 12);
        end
        rx_left--;
        rx_tick++;
        case (rx_mode)
            RX_ALWAYS: m_axis_tready <= 1'b1;
            RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
            RX_MOSTLY: m_axis_tready <= ($urandom_range(0, 9) != 0);
            default:   m_axis_tready <= ((rx_tick % rx_period) < (rx_period + 1) / 2);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) sb.decode_byte(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) sb.check_output(m_axis_tdata, m_axis_tuser);
        end
    end

    task automatic wait_drained();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] value);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        sb.set_capacity(value);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= CAP_W'($urandom);
    endtask

    function automatic void push_string(bit broken);
        logic [BYTE_W-1:0] s[$];
        logic [HEX_W-1:0]  v;
        logic [BYTE_W-1:0] ch;
        logic [3:0]        nib;
        int                len;
        int                n;
        s.push_back(CH_QUOTE);
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 12);
        repeat (len) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    ch = BYTE_W'($urandom_range(1, 255));
                    if (ch == CH_QUOTE || ch == CH_BSL) ch = "a";
                    s.push_back(ch);
                end
                5, 6: begin
                    s.push_back(CH_BSL);
                    case ($urandom_range(0, 8))
                        0: ch = "n";
                        1: ch = "t";
                        2: ch = "r";
                        3: ch = "b";
                        4: ch = "f";
                        5: ch = CH_QUOTE;
                        6: ch = CH_BSL;
                        7: ch = "/";
                        default: ch = BYTE_W'($urandom_range(1, 255));
                    endcase
                    s.push_back(ch);
                end
                default: begin
                    s.push_back(CH_BSL);
                    s.push_back("u");
                    if ($urandom_range(0, 1)) v = 16'($urandom_range(PRINT_LO, PRINT_HI));
                    else v = 16'($urandom);
                    for (int k = 3; k >= 0; k--) begin
                        nib = v[4*k +: 4];
                        if (nib < 10) ch = "0" + {4'd0, nib};
                        else ch = ($urandom_range(0, 1) ? "a" : "A") + {4'd0, nib} - 8'd10;
                        if ($urandom_range(0, 11) == 0) ch = BYTE_W'($urandom_range(1, 255));
                        s.push_back(ch);
                    end
                end
            endcase
        end
        s.push_back(CH_QUOTE);
        n = broken ? $urandom_range(1, s.size() - 1) : s.size();
        for (int k = 0; k < n; k++) byte_q.push_back(s[k]);
        if (broken && $urandom_range(0, 9) < 7) byte_q.push_back(CH_NUL);
    endfunction

    function automatic void build_phase(int n);
        int pick;
        while (byte_q.size() < n) begin
            pick = $urandom_range(0, 99);
            if (pick < 72) push_string(1'b0);
            else if (pick < 86) push_string(1'b1);
            else repeat ($urandom_range(1, 4)) byte_q.push_back(BYTE_W'($urandom_range(0, 255)));
        end
    endfunction

    task automatic send_stream(bit drain_once);
        int burst;
        int pause_at;
        bit gapless;
        gapless  = ($urandom_range(0, 3) == 0);
        burst    = $urandom_range(1, 24);
        pause_at = drain_once ? $urandom_range(1, byte_q.size() - 1) : -1;
        for (int i = 0; i < byte_q.size(); i++) begin
            if (i == pause_at) begin
                @(negedge i_clk);
                s_axis_tvalid <= 1'b0;
                while (sb.pending() != 0) @(posedge i_clk);
            end
            if (burst == 0) begin
                repeat ($urandom_range(1, 8)) begin
                    @(negedge i_clk);
                    s_axis_tvalid <= 1'b0;
                    s_axis_tdata  <= BYTE_W'($urandom);
                end
                burst = $urandom_range(1, 24);
            end
            if (!gapless) burst--;
            @(negedge i_clk);
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= byte_q[i];
            do @(posedge i_clk); while (!s_axis_tready);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        byte_q.delete();
    endtask

    initial begin
        logic [CAP_W-1:0] caps[8];
        sb = new();
        caps = '{13'd1, 13'd0, 13'd2, 13'd5, 13'd4096,
                 13'($urandom_range(3, 40)), 13'($urandom_range(41, 4096)), 13'd64};
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // idle errors, raw bytes, escapes, hex cut short, dropped hex, zero in idle, body, escape and second hex phase
        byte_q = '{"x", CH_NUL, CH_QUOTE, 8'hff, 8'h01, CH_BSL, "n", CH_BSL, CH_QUOTE,
                   CH_BSL, "u", "4", "a", "G", "1", CH_BSL, "u", "0", "0", "0", "1",
                   CH_QUOTE, CH_QUOTE, CH_BSL, CH_NUL, CH_QUOTE, CH_BSL, "u", "7", CH_NUL,
                   CH_QUOTE, CH_NUL};
        send_stream(1'b0);
        wait_drained();

        foreach (caps[p]) begin
            write_capacity(caps[p]);
            build_phase(100);
            send_stream(p == 0 || $urandom_range(0, 1));
            wait_drained();
        end

        repeat (8) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+design
design/jsu_pkg.sv
design/json_string_unescape_unit.sv
design/jsu_checker.sv
dv/jsu_unescape_sb_pkg.sv
dv/tb_top.sv
